### sv/dfc_pkg.sv
// Shared types and constants of the delimited frame capture unit.
package dfc_pkg;

    localparam int DEFAULT_FRAME_CAPACITY = 64;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 6;
    localparam int TRAILER_W = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [BYTE_W-1:0] CHAR_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_RBRACE = 8'h7D;

    localparam logic [TRAILER_W-1:0] TRAILER_LENGTH_RESET = 3'd3;
    localparam logic DELIVERY_ENABLE_RESET = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRAILER_LENGTH = 2'd0,
        CFG_DELIVERY_ENABLE = 2'd1
    } t_cfg_index;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0] t_len;

    typedef struct packed {
        logic valid;
        t_len len;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
        logic wr_bank;
        logic rd_bank;
        t_len len;
    } t_q_stat;

endpackage

### sv/dfc_if.sv
// Channel interfaces for received bytes, frame bytes and configuration writes.
interface dfc_rx_if;
    import dfc_pkg::*;
    logic valid;
    logic ready;
    t_byte rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfc_frame_if;
    import dfc_pkg::*;
    logic valid;
    logic ready;
    t_byte frame_byte;
    logic frame_last;
    t_len frame_length;
    modport source (output valid, output frame_byte, output frame_last,
                    output frame_length, input ready);
    modport sink (input valid, input frame_byte, input frame_last,
                  input frame_length, output ready);
endinterface

interface dfc_cfg_if;
    import dfc_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/dfc_front.sv
// Front end: configuration registers, byte classification and frame store writes.
module dfc_front #(
    parameter int FRAME_CAPACITY = dfc_pkg::DEFAULT_FRAME_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dfc_rx_if.sink           i_rx,
    dfc_cfg_if.sink          i_cfg,
    input  dfc_pkg::t_q_stat i_stat,
    output dfc_pkg::t_q_push o_push,
    output logic             o_wr_en,
    output logic [$clog2(FRAME_CAPACITY):0] o_wr_addr,
    output dfc_pkg::t_byte   o_wr_data
);
    import dfc_pkg::*;

    localparam int AW = $clog2(FRAME_CAPACITY);
    localparam int FW = $clog2(FRAME_CAPACITY + 1);

    logic [TRAILER_W-1:0] r_trailer_length;
    logic                 r_delivery_enable;
    logic                 r_open, n_open;
    logic                 r_armed, n_armed;
    logic [TRAILER_W-1:0] r_tc, n_tc;
    logic [FW-1:0]        r_fill, n_fill;

    logic          accept;
    logic          is_opener;
    logic          has_room;
    logic [AW-1:0] wr_idx;
    t_byte         b;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready = ~i_stat.full;
    assign accept = i_rx.valid & ~i_stat.full;
    assign b = i_rx.rx_byte;
    assign is_opener = (b == CHAR_LBRACE) || (b == CHAR_DOLLAR);
    assign has_room = r_fill < FW'(FRAME_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trailer_length <= TRAILER_LENGTH_RESET;
            r_delivery_enable <= DELIVERY_ENABLE_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_TRAILER_LENGTH) begin
                r_trailer_length <= i_cfg.data[TRAILER_W-1:0];
            end
            if (i_cfg.index == CFG_DELIVERY_ENABLE) begin
                r_delivery_enable <= i_cfg.data[0];
            end
        end
    end

    always_comb begin
        n_open = r_open;
        n_armed = r_armed;
        n_tc = r_tc;
        n_fill = r_fill;
        o_wr_en = 1'b0;
        wr_idx = AW'(r_fill);
        o_push = '0;
        if (accept) begin
            if (r_open && has_room) begin
                o_wr_en = 1'b1;
                n_fill = FW'(r_fill + 1'b1);
            end
            if (is_opener) begin
                n_open = 1'b1;
                o_wr_en = 1'b1;
                wr_idx = '0;
                n_fill = FW'(1);
            end
            if (b == CHAR_STAR) begin
                n_armed = 1'b1;
            end
            if (n_armed) begin
                n_tc = TRAILER_W'(r_tc + 1'b1);
            end
            if ((b == CHAR_RBRACE) || (n_tc == r_trailer_length)) begin
                o_push.valid = n_open && r_delivery_enable
                               && (n_fill < FW'(FRAME_CAPACITY));
                o_push.len = LEN_W'(n_fill);
                n_open = 1'b0;
                n_armed = 1'b0;
                n_tc = '0;
                n_fill = '0;
            end
        end
    end

    assign o_wr_addr = {i_stat.wr_bank, wr_idx};
    assign o_wr_data = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_armed <= 1'b0;
            r_tc <= '0;
            r_fill <= '0;
        end else begin
            r_open <= n_open;
            r_armed <= n_armed;
            r_tc <= n_tc;
            r_fill <= n_fill;
        end
    end

endmodule

### sv/dfc_desc_queue.sv
// Two-entry queue of finished frame lengths; entry slot i owns store bank i.
module dfc_desc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dfc_pkg::t_q_push i_push,
    input  logic             i_pop,
    output dfc_pkg::t_q_stat o_stat
);
    import dfc_pkg::*;

    localparam int DEPTH = 2;
    localparam int CW = $clog2(DEPTH + 1);

    t_len          r_len [DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_stat.full = r_count == CW'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_stat.wr_bank = r_wr_ptr;
    assign o_stat.rd_bank = r_rd_ptr;
    assign o_stat.len = r_len[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_len[r_wr_ptr] <= i_push.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push.valid && !i_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (!i_push.valid && i_pop) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_stat.full)
        else $error("Frame pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("Frame popped from an empty queue.");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Queue count exceeds its depth.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid && !i_pop |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("Queue count did not follow a push.");

endmodule

### sv/dfc_back.sv
// Back end: two-bank frame store and byte-by-byte emission of queued frames.
module dfc_back #(
    parameter int FRAME_CAPACITY = dfc_pkg::DEFAULT_FRAME_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dfc_pkg::t_q_stat i_stat,
    output logic             o_pop,
    input  logic             i_wr_en,
    input  logic [$clog2(FRAME_CAPACITY):0] i_wr_addr,
    input  dfc_pkg::t_byte   i_wr_data,
    dfc_frame_if.source      o_frame
);
    import dfc_pkg::*;

    localparam int AW = $clog2(FRAME_CAPACITY);
    localparam int MEM_DEPTH = 2 * (1 << AW);

    t_byte         r_mem [MEM_DEPTH];
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          r_valid, n_valid;
    t_byte         r_frame_byte;
    logic          r_frame_last;
    t_len          r_frame_length;

    logic advance;
    logic issue;
    logic last_now;

    assign advance = ~r_valid | o_frame.ready;
    assign issue = advance & ~i_stat.empty;
    assign last_now = LEN_W'(r_rd_idx) == LEN_W'(i_stat.len - 1'b1);
    assign o_pop = issue & last_now;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_frame_byte <= r_mem[{i_stat.rd_bank, r_rd_idx}];
            r_frame_last <= last_now;
            r_frame_length <= i_stat.len;
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_valid = r_valid;
        if (advance) begin
            n_valid = issue;
        end
        if (issue) begin
            n_rd_idx = last_now ? '0 : AW'(r_rd_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_valid <= n_valid;
        end
    end

    assign o_frame.valid = r_valid;
    assign o_frame.frame_byte = r_frame_byte;
    assign o_frame.frame_last = r_frame_last;
    assign o_frame.frame_length = r_frame_length;

endmodule

### sv/delimited_frame_capture_unit.sv
// Top level of the delimited frame capture unit.
// The unit takes one received byte per cycle and frames it: a frame opens on
// '{' or '$', closes on '}' or after trailer_length bytes counted from an
// asterisk, and a closed frame that fits is sent out, while delivery is
// enabled, one byte per cycle unless o_frame.ready holds it back, with its
// length and a last flag. The front end writes into one bank of a two-bank
// frame store while the back end reads the other, so a byte is accepted every
// cycle except while two finished frames are still waiting to be sent; then
// the input stalls until the back end has moved the last byte of the older one
// into its output register. A closed frame's length is registered in the
// queue before its bytes pass through the back end's output register. The
// store needs no clearing after reset; configuration writes never stall.
module delimited_frame_capture_unit #(
    parameter int FRAME_CAPACITY = dfc_pkg::DEFAULT_FRAME_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dfc_rx_if.sink      i_rx,
    dfc_cfg_if.sink     i_cfg,
    dfc_frame_if.source o_frame
);
    import dfc_pkg::*;

    localparam int AW = $clog2(FRAME_CAPACITY);

    t_q_push         push;
    t_q_stat         stat;
    logic            pop;
    logic            wr_en;
    logic [AW:0]     wr_addr;
    t_byte           wr_data;

    dfc_front #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_cfg     (i_cfg),
        .i_stat    (stat),
        .o_push    (push),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    dfc_desc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (stat)
    );

    dfc_back #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stat    (stat),
        .o_pop     (pop),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_frame   (o_frame)
    );

endmodule
